FILE: sv/piaw_pkg.sv
`timescale 1ns / 1ps

package piaw_pkg;

    // Default widths of a sample and of the integrator.
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int INTEG_WIDTH_DEF  = 40;

    // Configuration port geometry.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Register reset values.
    localparam logic [CFG_W-1:0] PROP_GAIN_RST  = 16'd256;
    localparam logic [CFG_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [CFG_W-1:0] TIME_STEP_RST  = 16'd4096;
    localparam logic [CFG_W-1:0] OUT_MIN_RST    = 16'd0;
    localparam logic [CFG_W-1:0] OUT_MAX_RST    = 16'd1280;

    // The proportional product is Q.16 and must be aligned with the Q.28 integral term.
    localparam int P_ALIGN   = 12;
    // The Q.28 sum is rounded half up to Q.8.
    localparam int RND_SHIFT = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_TIME_STEP  = 3'd2,
        REG_OUT_MIN    = 3'd3,
        REG_OUT_MAX    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MS_ERR_DT,
        MS_ERR_KP,
        MS_INT_LO,
        MS_INT_HI
    } mul_src_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_P,
        ACC_ADD_LO,
        ACC_ADD_HI
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL_DT,
        ST_CAND,
        ST_MUL_P,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_ACC_HI,
        ST_ROUND,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     sel_en;
        logic     mul_en;
        mul_src_t mul_src;
        logic     use_old;
        logic     cand_en;
        acc_op_t  acc_op;
        logic     round_en;
        logic     out_load;
        logic     held;
    } dp_cmd_t;

    typedef struct packed {
        logic out_of_range;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: sv/pi_pressure_controller_antiwindup_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     target, front, rear pressure
// m_        out        m_valid / m_ready     drive_voltage, front_selected, windup_held, clamped
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item occupies the controller from acceptance until its result register is loaded,
// and the PI sum is formed a second time when the integral update is discarded.
// All work passes through the single shared multiplier, which forms the time-step, the
// proportional and two integral partial products one after the other.
// A new item is accepted in the cycle after the result is loaded.
// Reset is synchronous and active low; it restores the register defaults and zeroes the integral.
// A stalled result waits in its register; the next item is already accepted and worked on.

module pi_pressure_controller_antiwindup_top #(
    parameter int SAMPLE_WIDTH = piaw_pkg::SAMPLE_WIDTH_DEF,
    parameter int INTEG_WIDTH  = piaw_pkg::INTEG_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_target_pressure,
    input  logic signed [SAMPLE_WIDTH-1:0] s_front_pressure,
    input  logic signed [SAMPLE_WIDTH-1:0] s_rear_pressure,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_drive_voltage,
    output logic                           m_front_selected,
    output logic                           m_windup_held,
    output logic                           m_clamped,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [piaw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [piaw_pkg::CFG_W-1:0]     cfg_data
);
    import piaw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    piaw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    piaw_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .INTEG_WIDTH  (INTEG_WIDTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_target_pressure (s_target_pressure),
        .s_front_pressure  (s_front_pressure),
        .s_rear_pressure   (s_rear_pressure),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive_voltage   (m_drive_voltage),
        .m_front_selected  (m_front_selected),
        .m_windup_held     (m_windup_held),
        .m_clamped         (m_clamped),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

FILE: sv/piaw_ctrl.sv
`timescale 1ns / 1ps

module piaw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  piaw_pkg::dp_status_t status,
    output piaw_pkg::dp_cmd_t    cmd
);
    import piaw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   held_reg;
    logic   held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            held_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        held_next   = held_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.mul_src = MS_ERR_DT;
        cmd.acc_op  = ACC_HOLD;
        cmd.use_old = held_reg;
        cmd.held    = held_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    held_next   = 1'b0;
                    state_next  = ST_SEL;
                end
            end
            ST_SEL: begin
                cmd.sel_en = 1'b1;
                state_next = ST_MUL_DT;
            end
            ST_MUL_DT: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_ERR_DT;
                state_next  = ST_CAND;
            end
            ST_CAND: begin
                cmd.cand_en = 1'b1;
                state_next  = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_ERR_KP;
                state_next  = ST_MUL_ILO;
            end
            // The accumulator takes the previous product while the next one is formed.
            ST_MUL_ILO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_INT_LO;
                cmd.acc_op  = ACC_LOAD_P;
                state_next  = ST_MUL_IHI;
            end
            ST_MUL_IHI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_INT_HI;
                cmd.acc_op  = ACC_ADD_LO;
                state_next  = ST_ACC_HI;
            end
            ST_ACC_HI: begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                // An out-of-range first pass is redone with the old integral.
                if (status.out_of_range && !held_reg) begin
                    held_next  = 1'b1;
                    state_next = ST_MUL_P;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/piaw_dp.sv
`timescale 1ns / 1ps

module piaw_dp #(
    parameter int SAMPLE_WIDTH = piaw_pkg::SAMPLE_WIDTH_DEF,
    parameter int INTEG_WIDTH  = piaw_pkg::INTEG_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_target_pressure,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_front_pressure,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_rear_pressure,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       m_drive_voltage,
    output logic                                 m_front_selected,
    output logic                                 m_windup_held,
    output logic                                 m_clamped,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [piaw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [piaw_pkg::CFG_W-1:0]           cfg_data,
    input  piaw_pkg::dp_cmd_t                    cmd,
    output piaw_pkg::dp_status_t                 status
);
    import piaw_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int IW    = INTEG_WIDTH;
    localparam int EW    = SW + 1;
    localparam int SEL_W = SW + 5;
    localparam int LO_W  = IW / 2;
    localparam int HI_W  = IW - LO_W;
    localparam int MA_W0 = (EW > LO_W + 1) ? EW : LO_W + 1;
    localparam int MA_W  = (MA_W0 > HI_W) ? MA_W0 : HI_W;
    localparam int MB_W  = CFG_W + 1;
    localparam int PR_W  = MA_W + MB_W;
    localparam int CS_W  = ((IW > PR_W) ? IW : PR_W) + 1;
    localparam int PT_W  = SW + CFG_W + 2 + P_ALIGN;
    localparam int IT_W  = IW + CFG_W + 1;
    localparam int ACC_W = ((PT_W > IT_W) ? PT_W : IT_W) + 1;
    localparam int Y_W   = ACC_W - RND_SHIFT;

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [IW-1:0]    IMAX     = {1'b0, {(IW - 1){1'b1}}};
    localparam logic signed [IW-1:0]    IMIN     = {1'b1, {(IW - 1){1'b0}}};

    // Configuration registers.
    logic        [CFG_W-1:0] prop_gain_reg;
    logic        [CFG_W-1:0] integ_gain_reg;
    logic        [CFG_W-1:0] time_step_reg;
    logic signed [CFG_W-1:0] out_min_reg;
    logic signed [CFG_W-1:0] out_max_reg;

    logic signed [SW-1:0]   target_reg;
    logic signed [SW-1:0]   front_reg;
    logic signed [SW-1:0]   rear_reg;
    logic                   use_front_reg;
    logic signed [EW-1:0]   err_reg;
    logic signed [PR_W-1:0] prod_reg;
    logic signed [IW-1:0]   cand_reg;
    logic signed [IW-1:0]   integ_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [Y_W-1:0]  y_reg;

    logic                   out_valid_reg;
    logic signed [SW-1:0]   drive_reg;
    logic                   front_sel_reg;
    logic                   held_out_reg;
    logic                   clamped_reg;

    logic signed [SEL_W-1:0] front_x10;
    logic signed [SEL_W-1:0] rear_x11;
    logic                    use_front_next;
    logic signed [SW-1:0]    press;
    logic signed [EW-1:0]    err_next;
    logic signed [IW-1:0]    int_src;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PR_W-1:0]  prod_next;
    logic signed [CS_W-1:0]  cand_sum;
    logic                    cand_fits;
    logic signed [IW-1:0]    cand_next;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [Y_W-1:0]   y_next;
    logic signed [Y_W-1:0]   min_ext;
    logic signed [Y_W-1:0]   max_ext;
    logic                    above_max;
    logic                    below_min;
    logic signed [Y_W-1:0]   y_final;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            time_step_reg  <= TIME_STEP_RST;
            out_min_reg    <= OUT_MIN_RST;
            out_max_reg    <= OUT_MAX_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                REG_TIME_STEP:  time_step_reg  <= cfg_data;
                REG_OUT_MIN:    out_min_reg    <= cfg_data;
                REG_OUT_MAX:    out_max_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front is used only when it reads more than 10% above rear.
    always_comb begin
        front_x10      = (SEL_W'(front_reg) <<< 3) + (SEL_W'(front_reg) <<< 1);
        rear_x11       = (SEL_W'(rear_reg) <<< 3) + (SEL_W'(rear_reg) <<< 1)
                         + SEL_W'(rear_reg);
        use_front_next = front_x10 > rear_x11;
        press          = use_front_next ? front_reg : rear_reg;
        err_next       = EW'(target_reg) - EW'(press);
    end

    // One shared signed multiplier; every product has a 16-bit unsigned register as one factor.
    always_comb begin
        int_src = cmd.use_old ? integ_reg : cand_reg;
        unique case (cmd.mul_src)
            MS_ERR_DT: begin
                mul_a = MA_W'(err_reg);
                mul_b = signed'({1'b0, time_step_reg});
            end
            MS_ERR_KP: begin
                mul_a = MA_W'(err_reg);
                mul_b = signed'({1'b0, prop_gain_reg});
            end
            MS_INT_LO: begin
                mul_a = MA_W'(signed'({1'b0, int_src[LO_W-1:0]}));
                mul_b = signed'({1'b0, integ_gain_reg});
            end
            MS_INT_HI: begin
                mul_a = MA_W'(signed'(int_src[IW-1:LO_W]));
                mul_b = signed'({1'b0, integ_gain_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PR_W'(mul_a) * PR_W'(mul_b);
    end

    // Candidate integral, saturated to the integrator range.
    always_comb begin
        cand_sum  = CS_W'(integ_reg) + CS_W'(prod_reg);
        cand_fits = (cand_sum[CS_W-1:IW-1] == '0) || (cand_sum[CS_W-1:IW-1] == '1);
        if (cand_fits) begin
            cand_next = cand_sum[IW-1:0];
        end else if (cand_sum[CS_W-1]) begin
            cand_next = IMIN;
        end else begin
            cand_next = IMAX;
        end
    end

    always_comb begin
        unique case (cmd.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_LOAD_P: acc_next = ACC_W'(prod_reg) <<< P_ALIGN;
            ACC_ADD_LO: acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_ADD_HI: acc_next = acc_reg + (ACC_W'(prod_reg) <<< LO_W);
            default:    acc_next = acc_reg;
        endcase
        rnd_sum = acc_reg + RND_BIAS;
        y_next  = Y_W'(rnd_sum >>> RND_SHIFT);
    end

    // With inverted limits, a value that violates both bounds takes the upper bound.
    always_comb begin
        min_ext   = Y_W'(out_min_reg);
        max_ext   = Y_W'(out_max_reg);
        above_max = y_reg > max_ext;
        below_min = y_reg < min_ext;
        if (above_max) begin
            y_final = max_ext;
        end else if (below_min) begin
            y_final = min_ext;
        end else begin
            y_final = y_reg;
        end
        status.out_of_range = above_max || below_min;
        status.out_busy     = out_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            target_reg <= s_target_pressure;
            front_reg  <= s_front_pressure;
            rear_reg   <= s_rear_pressure;
        end
        if (cmd.sel_en) begin
            use_front_reg <= use_front_next;
            err_reg       <= err_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.cand_en) begin
            cand_reg <= cand_next;
        end
        acc_reg <= acc_next;
        if (cmd.round_en) begin
            y_reg <= y_next;
        end
        if (cmd.out_load) begin
            drive_reg     <= y_final[SW-1:0];
            front_sel_reg <= use_front_reg;
            held_out_reg  <= cmd.held;
            clamped_reg   <= above_max || below_min;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load && !cmd.held) begin
                integ_reg <= cand_reg;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_drive_voltage  = drive_reg;
    assign m_front_selected = front_sel_reg;
    assign m_windup_held    = held_out_reg;
    assign m_clamped        = clamped_reg;

endmodule

FILE: sv/piaw_checker.sv
`timescale 1ns / 1ps

module piaw_checker #(
    parameter int SAMPLE_WIDTH = piaw_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [SAMPLE_WIDTH-1:0] m_drive_voltage,
    input logic                    m_front_selected,
    input logic                    m_windup_held,
    input logic                    m_clamped
);
    import piaw_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_voltage)
        && $stable(m_front_selected) && $stable(m_windup_held) && $stable(m_clamped))
        else $error("stalled result changed");

    // One item is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // A result appears only as the controller returns to idle.
    a_result_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared while controller busy");

endmodule

bind pi_pressure_controller_antiwindup_top piaw_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_piaw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_drive_voltage  (m_drive_voltage),
    .m_front_selected (m_front_selected),
    .m_windup_held    (m_windup_held),
    .m_clamped        (m_clamped)
);
